/* hw/rtl/hashed_gaussian_mode_noise_macros.svh */
// Assertion macros shared by the noise generator RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef HASHED_GAUSSIAN_MODE_NOISE_MACROS_SVH
`define HASHED_GAUSSIAN_MODE_NOISE_MACROS_SVH

// Same-cycle implication.
`define HGMN_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("hgmn: same-cycle check failed");

// Next-cycle implication.
`define HGMN_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("hgmn: next-cycle check failed");

`endif

/* hw/rtl/hgmn_pkg.sv */
// Shared types and constants of the hashed Gaussian mode noise pipeline.
// No dependencies; every module of the block imports it.
package hgmn_pkg;

   // stage counts of each pipeline section
   localparam int HASH_LAT      = 6;
   localparam int RAD_LAT       = 60;
   localparam int TRIG_CORE_LAT = 23;
   localparam int TRIG_PAD      = RAD_LAT - TRIG_CORE_LAT;
   localparam int SCALE_LAT     = 3;
   localparam int TOTAL_LAT     = HASH_LAT + RAD_LAT + SCALE_LAT;

   // splitmix64 constants
   localparam logic [63:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Horner divisors, first step first (k = 6 down to 1)
   localparam logic [7:0] SIN_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

   localparam logic [8:0] GRID_Y_RESET = 9'd256;

   typedef enum logic [1:0] {
      REG_SEED,
      REG_CHANNEL,
      REG_GRID_Y,
      REG_SIGMA
   } csr_index_type;

   typedef struct packed {
      logic zero;
      logic neg_imag;
   } hgmn_flags_type;

endpackage

/* hw/rtl/hashed_gaussian_mode_noise.sv */
// Hashed Gaussian mode noise: one (real, imag) pair per mode coordinate.
// Sections in order: hash, radius with log2 squarings and root, scale.
// Throughput one transfer per cycle unless stalled; 32 squaring and 24 root stages set the depth.
// A stalled output freezes the whole pipeline. Synchronous reset clears all valid
// bits and sets seed 0, channel 0, grid_y 256, sigma 0.
`include "hashed_gaussian_mode_noise_macros.svh"
module hashed_gaussian_mode_noise
   import hgmn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_mode_x,
   input  logic [7:0]         req_mode_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [36:0] rsp_real_part,
   output logic signed [36:0] rsp_imag_part,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [31:0]    seed_ff;
   logic           channel_ff;
   logic [8:0]     grid_y_ff;
   logic [31:0]    sigma_ff;
   logic           cfg_we;
   csr_index_type  cfg_idx;

   logic                 adv;
   logic [TOTAL_LAT-1:0] valid_ff;
   logic [TOTAL_LAT-1:0] valid_in;

   logic [52:0]        u1;
   logic [31:0]        phase;
   hgmn_flags_type     hash_flags;
   hgmn_flags_type     flags_dly_ff [RAD_LAT];
   logic [23:0]        radius;
   logic signed [31:0] cos_val;
   logic signed [31:0] sin_val;

   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite;
   assign cfg_idx = csr_index_type'(paddr[3:2]);

   always_comb begin
      case (cfg_idx)
         REG_SEED:    prdata = seed_ff;
         REG_CHANNEL: prdata = {31'd0, channel_ff};
         REG_GRID_Y:  prdata = {23'd0, grid_y_ff};
         REG_SIGMA:   prdata = sigma_ff;
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         channel_ff <= 1'b0;
         grid_y_ff  <= GRID_Y_RESET;
         sigma_ff   <= '0;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_SEED:    seed_ff    <= pwdata;
            REG_CHANNEL: channel_ff <= pwdata[0];
            REG_GRID_Y:  grid_y_ff  <= pwdata[8:0];
            REG_SIGMA:   sigma_ff   <= pwdata;
            default:     ;
         endcase
      end
   end

   // whole pipe moves together; it holds only when the output transfer waits
   assign adv       = !valid_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[TOTAL_LAT-1];
   assign valid_in  = {valid_ff[TOTAL_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   hgmn_hash u_hash (
      .clock   (clock),
      .en      (adv),
      .mode_x  (req_mode_x),
      .mode_y  (req_mode_y),
      .seed    (seed_ff),
      .channel (channel_ff),
      .grid_y  (grid_y_ff),
      .u1      (u1),
      .phase   (phase),
      .flags   (hash_flags)
   );

   hgmn_radius u_radius (
      .clock (clock),
      .en    (adv),
      .u1    (u1),
      .r     (radius)
   );

   hgmn_trig u_trig (
      .clock   (clock),
      .en      (adv),
      .phase   (phase),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         flags_dly_ff[0] <= hash_flags;
         for (int s = 1; s < RAD_LAT; s++) begin
            flags_dly_ff[s] <= flags_dly_ff[s-1];
         end
      end
   end

   hgmn_scale u_scale (
      .clock     (clock),
      .en        (adv),
      .r         (radius),
      .cos_val   (cos_val),
      .sin_val   (sin_val),
      .flags     (flags_dly_ff[RAD_LAT-1]),
      .sigma     (sigma_ff),
      .real_part (rsp_real_part),
      .imag_part (rsp_imag_part)
   );

   `HGMN_ASSERT_SAME(a_full_stop, rsp_valid && !rsp_ready, !req_ready)
   `HGMN_ASSERT_NEXT(a_stall_hold, !adv, valid_ff == $past(valid_ff))
   `HGMN_ASSERT_SAME(a_reset_empty, $past(reset), valid_ff == '0)
   `HGMN_ASSERT_NEXT(a_grid_write, cfg_we && cfg_idx == REG_GRID_Y, grid_y_ff == $past(pwdata[8:0]))

endmodule

/* hw/rtl/hgmn_hash.sv */
// Key build and two parallel splitmix64 hashes, six register stages.
// Depends on hgmn_pkg.
module hgmn_hash
   import hgmn_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [7:0]     mode_x,
   input  logic [7:0]     mode_y,
   input  logic [31:0]    seed,
   input  logic           channel,
   input  logic [8:0]     grid_y,
   output logic [52:0]    u1,
   output logic [31:0]    phase,
   output hgmn_flags_type flags
);

   logic           ky_pos;
   logic           gx_zero;
   logic [9:0]     ky_w;
   logic [9:0]     pky_w;
   logic [31:0]    pky_ext;
   logic [63:0]    key_in;
   hgmn_flags_type flags_in;

   logic [63:0] key_ff [2];
   logic [63:0] v1_w   [2];
   logic [63:0] a_in   [2];
   logic [63:0] a_ff   [2];
   logic [63:0] lh1_w  [2];
   logic [63:0] hl1_w  [2];
   logic [63:0] pll_in [2];
   logic [63:0] pll_ff [2];
   logic [31:0] crs_in [2];
   logic [31:0] crs_ff [2];
   logic [63:0] b_w    [2];
   logic [63:0] c_in   [2];
   logic [63:0] c_ff   [2];
   logic [63:0] lh2_w  [2];
   logic [63:0] hl2_w  [2];
   logic [63:0] qll_in [2];
   logic [63:0] qll_ff [2];
   logic [31:0] qcr_in [2];
   logic [31:0] qcr_ff [2];
   logic [63:0] d_w    [2];
   logic [63:0] h_in   [2];
   logic [63:0] h_ff   [2];

   hgmn_flags_type flg_ff [HASH_LAT];

   // signed wavenumber, Hermitian phase on the gx = 0 column, key
   always_comb begin
      ky_pos   = mode_y <= grid_y[8:1];
      ky_w     = ky_pos ? {2'b00, mode_y} : {2'b00, mode_y} - {1'b0, grid_y};
      gx_zero  = mode_x == 8'd0;
      pky_w    = (gx_zero && ky_w[9]) ? 10'd0 - ky_w : ky_w;
      pky_ext  = {{22{pky_w[9]}}, pky_w};
      key_in   = {32'd0, seed} ^ {15'd0, channel, 48'd0} ^ {24'd0, mode_x, 32'd0}
               ^ {24'd0, pky_ext, 8'd0};
      flags_in.zero     = gx_zero && (ky_w == 10'd0);
      flags_in.neg_imag = gx_zero && ky_w[9];
   end

   // 64x64 low products split into a full low partial and two cross terms
   always_comb begin
      for (int d = 0; d < 2; d++) begin
         v1_w[d]   = key_ff[d] + MIX_ADD;
         a_in[d]   = v1_w[d] ^ (v1_w[d] >> 30);
         pll_in[d] = {32'd0, a_ff[d][31:0]} * {32'd0, MIX_MUL1[31:0]};
         lh1_w[d]  = {32'd0, a_ff[d][31:0]} * {32'd0, MIX_MUL1[63:32]};
         hl1_w[d]  = {32'd0, a_ff[d][63:32]} * {32'd0, MIX_MUL1[31:0]};
         crs_in[d] = lh1_w[d][31:0] + hl1_w[d][31:0];
         b_w[d]    = pll_ff[d] + {crs_ff[d], 32'd0};
         c_in[d]   = b_w[d] ^ (b_w[d] >> 27);
         qll_in[d] = {32'd0, c_ff[d][31:0]} * {32'd0, MIX_MUL2[31:0]};
         lh2_w[d]  = {32'd0, c_ff[d][31:0]} * {32'd0, MIX_MUL2[63:32]};
         hl2_w[d]  = {32'd0, c_ff[d][63:32]} * {32'd0, MIX_MUL2[31:0]};
         qcr_in[d] = lh2_w[d][31:0] + hl2_w[d][31:0];
         d_w[d]    = qll_ff[d] + {qcr_ff[d], 32'd0};
         h_in[d]   = d_w[d] ^ (d_w[d] >> 31);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         key_ff[0] <= key_in;
         key_ff[1] <= key_in ^ 64'd1;
         for (int d = 0; d < 2; d++) begin
            a_ff[d]   <= a_in[d];
            pll_ff[d] <= pll_in[d];
            crs_ff[d] <= crs_in[d];
            c_ff[d]   <= c_in[d];
            qll_ff[d] <= qll_in[d];
            qcr_ff[d] <= qcr_in[d];
            h_ff[d]   <= h_in[d];
         end
         flg_ff[0] <= flags_in;
         for (int s = 1; s < HASH_LAT; s++) begin
            flg_ff[s] <= flg_ff[s-1];
         end
      end
   end

   assign u1    = h_ff[0][63:11];
   assign phase = h_ff[1][63:32];
   assign flags = flg_ff[HASH_LAT-1];

endmodule

/* hw/rtl/hgmn_radius.sv */
// Box-Muller radius sqrt(-2 ln u) in Q.20: normalize, 32 squaring stages
// for log2, scale by 2 ln2, then a 24-stage bit-per-stage square root. Uses hgmn_pkg.
module hgmn_radius
   import hgmn_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [52:0] u1,
   output logic [23:0] r
);

   logic [52:0] u_in;
   logic [5:0]  p_in;
   logic [52:0] u_ff;
   logic [5:0]  p_ff;
   logic [31:0] m_in;

   logic [31:0] m_ff    [33];
   logic [31:0] frac_ff [33];
   logic [5:0]  pl_ff   [33];

   logic [37:0] lq_w;
   logic [29:0] lq_ff;
   logic [60:0] e_w;

   logic [47:0] v_ff   [25];
   logic [47:0] res_ff [25];

   // zero u1 is clamped to one step; msb search
   always_comb begin
      u_in = (u1 == '0) ? 53'd1 : u1;
      p_in = '0;
      for (int i = 0; i < 53; i++) begin
         if (u_in[i]) p_in = 6'(i);
      end
      m_in = (p_ff >= 6'd31) ? 32'(u_ff >> (p_ff - 6'd31)) : 32'(u_ff << (6'd31 - p_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff       <= u_in;
         p_ff       <= p_in;
         m_ff[0]    <= m_in;
         frac_ff[0] <= '0;
         pl_ff[0]   <= p_ff;
      end
   end

   // one fraction bit of log2 per stage
   for (genvar i = 0; i < 32; i++) begin : g_log
      logic [63:0] sq_w;
      logic [32:0] t_w;
      logic [31:0] m_in_s;
      logic [31:0] frac_in;
      always_comb begin
         sq_w    = {32'd0, m_ff[i]} * {32'd0, m_ff[i]};
         t_w     = sq_w[63:31];
         m_in_s  = t_w[32] ? t_w[32:1] : t_w[31:0];
         frac_in = {frac_ff[i][30:0], t_w[32]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i+1]    <= m_in_s;
            frac_ff[i+1] <= frac_in;
            pl_ff[i+1]   <= pl_ff[i];
         end
      end
   end

   // -log2 in Q.32, then E = 2 ln2 * L in Q.40
   assign lq_w = {6'd53 - pl_ff[32], 32'd0} - {6'd0, frac_ff[32]};
   assign e_w  = {31'd0, lq_ff} * {30'd0, TWO_LN2_Q30};

   always_ff @(posedge clock) begin
      if (en) begin
         lq_ff     <= lq_w[37:8];
         v_ff[0]   <= {1'b0, e_w[60:14]};
         res_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < 24; j++) begin : g_sqrt
      localparam logic [47:0] BIT = 48'd1 << (46 - 2*j);
      logic [47:0] trial_w;
      logic [47:0] v_in;
      logic [47:0] res_in;
      always_comb begin
         trial_w = res_ff[j] + BIT;
         if (v_ff[j] >= trial_w) begin
            v_in   = v_ff[j] - trial_w;
            res_in = (res_ff[j] >> 1) + BIT;
         end else begin
            v_in   = v_ff[j];
            res_in = res_ff[j] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[j+1]   <= v_in;
            res_ff[j+1] <= res_in;
         end
      end
   end

   assign r = res_ff[24][23:0];

endmodule

/* hw/rtl/hgmn_trig.sv */
// Phase to (cos, sin) in Q.30: octant reduction, Horner polynomials with
// reciprocal-multiply division, quadrant mapping, then a delay to match the radius path.
// Uses hgmn_pkg.
module hgmn_trig
   import hgmn_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_val,
   output logic signed [31:0] sin_val
);

   typedef enum logic [1:0] {
      QUAD_I,
      QUAD_II,
      QUAD_III,
      QUAD_IV
   } quad_type;

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      quad_type    quad;
      logic        swap;
   } trig_side_type;

   logic [30:0] g_w;
   logic [29:0] g_ff;
   quad_type    q0_ff;
   logic        sw0_ff;
   logic [60:0] xp_w;
   logic [29:0] x_ff;
   quad_type    q1_ff;
   logic        sw1_ff;
   logic [59:0] x2p_w;

   trig_side_type side_ff [19];

   logic [30:0] ts_ff  [1:6];
   logic [30:0] tc_ff  [1:6];
   logic [30:0] ns_ff  [6];
   logic [30:0] nc_ff  [6];
   logic [30:0] nsb_ff [6];
   logic [30:0] ncb_ff [6];
   logic [30:0] q0s_ff [6];
   logic [30:0] q0c_ff [6];

   logic [60:0]        sp_w;
   logic [30:0]        s_ff;
   logic [30:0]        c_ff;
   quad_type           qf_ff;
   logic               swf_ff;
   logic [30:0]        sq_w;
   logic [30:0]        cq_w;
   logic signed [31:0] cv_in;
   logic signed [31:0] sv_in;
   logic signed [31:0] cv_ff [TRIG_PAD+1];
   logic signed [31:0] sv_ff [TRIG_PAD+1];

   // fold the quadrant fraction into an octant
   assign g_w   = phase[29] ? Q30_ONE - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
   assign xp_w  = {31'd0, g_ff} * {30'd0, HALF_PI_Q30};
   assign x2p_w = {30'd0, x_ff} * {30'd0, x_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff            <= g_w[29:0];
         q0_ff           <= quad_type'(phase[31:30]);
         sw0_ff          <= phase[29];
         x_ff            <= xp_w[59:30];
         q1_ff           <= q0_ff;
         sw1_ff          <= sw0_ff;
         side_ff[0].x    <= x_ff;
         side_ff[0].x2   <= x2p_w[59:30];
         side_ff[0].quad <= q1_ff;
         side_ff[0].swap <= sw1_ff;
         for (int s = 1; s < 19; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // each Horner step: product, reciprocal multiply, remainder correction
   for (genvar i = 0; i < 6; i++) begin : g_horner
      localparam logic [7:0]  DS = SIN_DIV[i];
      localparam logic [7:0]  DC = COS_DIV[i];
      localparam logic [31:0] RS = 32'(64'h1_0000_0000 / DS);
      localparam logic [31:0] RC = 32'(64'h1_0000_0000 / DC);
      logic [30:0] ts_cur;
      logic [30:0] tc_cur;
      logic [60:0] ps_w;
      logic [60:0] pc_w;
      logic [62:0] rs_w;
      logic [62:0] rc_w;
      logic [38:0] rem_s;
      logic [38:0] rem_c;
      logic [30:0] qs_w;
      logic [30:0] qc_w;
      if (i == 0) begin : g_first
         assign ts_cur = Q30_ONE;
         assign tc_cur = Q30_ONE;
      end else begin : g_next
         assign ts_cur = ts_ff[i];
         assign tc_cur = tc_ff[i];
      end
      always_comb begin
         ps_w  = {31'd0, side_ff[3*i].x2} * {30'd0, ts_cur};
         pc_w  = {31'd0, side_ff[3*i].x2} * {30'd0, tc_cur};
         rs_w  = {32'd0, ns_ff[i]} * {31'd0, RS};
         rc_w  = {32'd0, nc_ff[i]} * {31'd0, RC};
         rem_s = {8'd0, nsb_ff[i]} - {8'd0, q0s_ff[i]} * {31'd0, DS};
         rem_c = {8'd0, ncb_ff[i]} - {8'd0, q0c_ff[i]} * {31'd0, DC};
         qs_w  = (rem_s >= {31'd0, DS}) ? q0s_ff[i] + 31'd1 : q0s_ff[i];
         qc_w  = (rem_c >= {31'd0, DC}) ? q0c_ff[i] + 31'd1 : q0c_ff[i];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ns_ff[i]    <= ps_w[60:30];
            nc_ff[i]    <= pc_w[60:30];
            q0s_ff[i]   <= rs_w[62:32];
            q0c_ff[i]   <= rc_w[62:32];
            nsb_ff[i]   <= ns_ff[i];
            ncb_ff[i]   <= nc_ff[i];
            ts_ff[i+1]  <= Q30_ONE - qs_w;
            tc_ff[i+1]  <= Q30_ONE - qc_w;
         end
      end
   end

   assign sp_w = {31'd0, side_ff[18].x} * {30'd0, ts_ff[6]};

   always_comb begin
      sq_w = swf_ff ? c_ff : s_ff;
      cq_w = swf_ff ? s_ff : c_ff;
      case (qf_ff)
         QUAD_I: begin
            cv_in = $signed({1'b0, cq_w});
            sv_in = $signed({1'b0, sq_w});
         end
         QUAD_II: begin
            cv_in = -$signed({1'b0, sq_w});
            sv_in = $signed({1'b0, cq_w});
         end
         QUAD_III: begin
            cv_in = -$signed({1'b0, cq_w});
            sv_in = -$signed({1'b0, sq_w});
         end
         QUAD_IV: begin
            cv_in = $signed({1'b0, sq_w});
            sv_in = -$signed({1'b0, cq_w});
         end
         default: begin
            cv_in = '0;
            sv_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= sp_w[60:30];
         c_ff     <= tc_ff[6];
         qf_ff    <= side_ff[18].quad;
         swf_ff   <= side_ff[18].swap;
         cv_ff[0] <= cv_in;
         sv_ff[0] <= sv_in;
         for (int s = 1; s <= TRIG_PAD; s++) begin
            cv_ff[s] <= cv_ff[s-1];
            sv_ff[s] <= sv_ff[s-1];
         end
      end
   end

   assign cos_val = cv_ff[TRIG_PAD];
   assign sin_val = sv_ff[TRIG_PAD];

endmodule

/* hw/rtl/hgmn_scale.sv */
// Radius times (cos, sin), sigma scaling with rounding, saturation to Q20.16.
// Three register stages; uses hgmn_pkg.
module hgmn_scale
   import hgmn_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [23:0]        r,
   input  logic signed [31:0] cos_val,
   input  logic signed [31:0] sin_val,
   input  hgmn_flags_type     flags,
   input  logic [31:0]        sigma,
   output logic signed [36:0] real_part,
   output logic signed [36:0] imag_part
);

   localparam logic [37:0] NEG_LIM = 38'h10_0000_0000;
   localparam logic [37:0] POS_LIM = 38'h0F_FFFF_FFFF;

   function automatic logic signed [36:0] clamp_part(input logic [37:0] mag,
                                                     input logic neg, input logic zero);
      logic [37:0] lim;
      begin
         lim = '0;
         if (zero || mag == '0) begin
            return '0;
         end
         if (neg) begin
            lim = (mag > NEG_LIM) ? NEG_LIM : mag;
            return $signed(37'(38'd0 - lim));
         end
         lim = (mag > POS_LIM) ? POS_LIM : mag;
         return $signed(lim[36:0]);
      end
   endfunction

   logic [31:0]    cmag_w;
   logic [31:0]    smag_w;
   logic [54:0]    mc_w;
   logic [54:0]    ms_w;
   logic [24:0]    mc_ff;
   logic [24:0]    ms_ff;
   logic [57:0]    vc_w;
   logic [57:0]    vs_w;
   logic [37:0]    vc_ff;
   logic [37:0]    vs_ff;
   logic           negc_ff [2];
   logic           negs_ff [2];
   hgmn_flags_type flg_ff  [2];

   always_comb begin
      cmag_w = cos_val[31] ? 32'd0 - cos_val : cos_val;
      smag_w = sin_val[31] ? 32'd0 - sin_val : sin_val;
      mc_w   = {31'd0, r} * {24'd0, cmag_w[30:0]};
      ms_w   = {31'd0, r} * {24'd0, smag_w[30:0]};
      vc_w   = {33'd0, mc_ff} * {26'd0, sigma} + 58'h8_0000;
      vs_w   = {33'd0, ms_ff} * {26'd0, sigma} + 58'h8_0000;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mc_ff      <= mc_w[54:30];
         ms_ff      <= ms_w[54:30];
         negc_ff[0] <= cos_val[31];
         negs_ff[0] <= sin_val[31] ^ flags.neg_imag;
         flg_ff[0]  <= flags;
         vc_ff      <= vc_w[57:20];
         vs_ff      <= vs_w[57:20];
         negc_ff[1] <= negc_ff[0];
         negs_ff[1] <= negs_ff[0];
         flg_ff[1]  <= flg_ff[0];
         real_part  <= clamp_part(vc_ff, negc_ff[1], flg_ff[1].zero);
         imag_part  <= clamp_part(vs_ff, negs_ff[1], flg_ff[1].zero);
      end
   end

endmodule
